@@ sv/usd_pkg.sv @@
// ----------------------------------------------------------------------------
// usd_pkg
// Shared types and constants of the ultrasonic sector sweep detector.
// ----------------------------------------------------------------------------
package usd_pkg;

    localparam int USD_NUM_SECTORS     = 5;
    localparam int USD_STEPS_PER_SWEEP = 9;
    localparam int USD_ANGLE_STEP_DEG  = 30;

    localparam int USD_ECHO_W  = 16;
    localparam int USD_DIST_W  = 11;
    localparam int USD_ANGLE_W = 8;
    localparam int USD_MASK_W  = 5;

    // cm = floor(floor(d/2)*10/291) = (floor(d/2) * 10 * ceil(2^28/291)) >> 28,
    // exact for every 16-bit echo width
    localparam int          USD_RECIP_W     = 24;
    localparam int          USD_RECIP_SHIFT = 28;
    localparam int          USD_HALF_W      = USD_ECHO_W - 1;
    localparam int          USD_PROD_W      = USD_HALF_W + USD_RECIP_W;
    localparam logic [USD_RECIP_W-1:0] USD_CM_RECIP = 24'd9224590;

    // configuration port
    localparam int                  USD_ADDR_W     = 3;
    localparam int                  USD_DATA_W     = 32;
    localparam logic                USD_REG_THRESH = 1'b0;
    localparam logic [USD_DIST_W-1:0] USD_THRESH_RST = 11'd30;

    typedef struct packed {
        logic load;      // capture the accepted echo word
        logic mul;       // convert echo width to centimeters
        logic upd;       // write the sector, move the servo index
        logic scan;      // test one sector against the threshold
        logic div;       // one quotient bit of the mean
        logic out_load;  // move the result into the output register
    } usd_cmd_t;

    typedef struct packed {
        logic sweep_end;
        logic scan_last;
        logic div_last;
        logic out_free;
    } usd_sts_t;

endpackage

@@ sv/usd_ctrl.sv @@
// ----------------------------------------------------------------------------
// usd_ctrl
// Sequencer: accept, convert, update, scan sectors, divide, deliver.
// ----------------------------------------------------------------------------
module usd_ctrl
    import usd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  usd_sts_t sts,
    output usd_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_UPD  = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = sts.sweep_end ? ST_SCAN : ST_OUT;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // hold until the output register is empty or being taken
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/usd_dp.sv @@
// ----------------------------------------------------------------------------
// usd_dp
// Datapath: echo conversion, sector stores, sweep walk, near scan,
// serial mean divider and output register.
// ----------------------------------------------------------------------------
module usd_dp
    import usd_pkg::*;
#(
    parameter int NUM_SECTORS     = USD_NUM_SECTORS,
    parameter int STEPS_PER_SWEEP = USD_STEPS_PER_SWEEP,
    parameter int ANGLE_STEP_DEG  = USD_ANGLE_STEP_DEG
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  usd_cmd_t               cmd,
    output usd_sts_t               sts,
    input  logic [USD_ECHO_W-1:0]  echo_duration_us,
    input  logic [USD_DIST_W-1:0]  near_threshold_cm,
    input  logic                   out_stall,
    output logic                   out_valid,
    output logic [USD_ANGLE_W-1:0] servo_angle,
    output logic                   sweep_done,
    output logic [USD_MASK_W-1:0]  obstacle_mask,
    output logic [USD_DIST_W-1:0]  mean_distance_cm
);

    localparam int IW  = $clog2(NUM_SECTORS);
    localparam int STW = $clog2(STEPS_PER_SWEEP);
    localparam int SW  = USD_DIST_W + $clog2(NUM_SECTORS);
    localparam int CW  = $clog2(NUM_SECTORS + 1);
    localparam int DCW = $clog2(SW);

    localparam logic [IW-1:0]  SEC_TOP   = IW'(NUM_SECTORS - 1);
    localparam logic [IW-1:0]  SEC_RST   = IW'((NUM_SECTORS - 1) / 2);
    localparam logic [STW-1:0] STEP_LAST = STW'(STEPS_PER_SWEEP - 1);
    localparam logic [DCW-1:0] DIV_LAST  = DCW'(SW - 1);

    logic [USD_ECHO_W-1:0]  echo_reg;
    logic [USD_DIST_W-1:0]  cm_reg;
    logic [USD_DIST_W-1:0]  cur_reg  [NUM_SECTORS];
    logic [USD_DIST_W-1:0]  cur_next [NUM_SECTORS];
    logic [USD_DIST_W-1:0]  prev_reg [NUM_SECTORS];
    logic [USD_DIST_W-1:0]  prev_next[NUM_SECTORS];
    logic [IW-1:0]          sec_reg,  sec_next;
    logic                   up_reg,   up_next;
    logic [STW-1:0]         step_reg, step_next;
    logic                   done_reg, done_next;
    logic [IW-1:0]          scan_reg, scan_next;
    logic [SW-1:0]          acc_reg,  acc_next;
    logic [CW-1:0]          cnt_reg,  cnt_next;
    logic [CW-1:0]          rem_reg,  rem_next;
    logic [NUM_SECTORS-1:0] mask_reg, mask_next;
    logic [DCW-1:0]         dcnt_reg, dcnt_next;

    logic                   ovalid_reg, ovalid_next;
    logic [USD_ANGLE_W-1:0] angle_reg,  angle_next;
    logic                   odone_reg,  odone_next;
    logic [USD_MASK_W-1:0]  omask_reg,  omask_next;
    logic [USD_DIST_W-1:0]  omean_reg,  omean_next;

    logic [USD_PROD_W-1:0]  prod;
    logic [IW-1:0]          s_eff;
    logic [IW-1:0]          rd_idx;
    logic [USD_DIST_W-1:0]  cur_rd;
    logic [USD_DIST_W-1:0]  prev_rd;
    logic [USD_DIST_W-1:0]  old_val;
    logic [USD_DIST_W:0]    avg_sum;
    logic [USD_DIST_W-1:0]  new_val;
    logic                   step_last;
    logic                   at_top;
    logic                   at_bot;
    logic                   dir_up;
    logic                   near;
    logic [CW:0]            rem_sh;
    logic [CW:0]            rem_sub;
    logic                   rem_ge;
    logic [USD_MASK_W+NUM_SECTORS-1:0] mask_wide;
    int                     angle_full;

    assign prod = USD_PROD_W'(echo_reg[USD_ECHO_W-1:1]) * USD_PROD_W'(USD_CM_RECIP);

    assign s_eff   = (sec_reg > SEC_TOP) ? SEC_TOP : sec_reg;
    assign rd_idx  = cmd.scan ? scan_reg : s_eff;
    assign cur_rd  = cur_reg[rd_idx];
    assign prev_rd = prev_reg[rd_idx];

    assign step_last = (step_reg == STEP_LAST);
    // first step of a sweep sees a cleared sector
    assign old_val   = (step_reg == '0) ? '0 : cur_rd;
    assign avg_sum   = {1'b0, old_val} + {1'b0, cm_reg};
    assign new_val   = (old_val == '0) ? cm_reg : avg_sum[USD_DIST_W:1];

    assign at_top = (s_eff == SEC_TOP);
    assign at_bot = (s_eff == '0);
    assign dir_up = at_top ? 1'b0 : (at_bot ? 1'b1 : up_reg);

    assign near = (prev_rd <= near_threshold_cm) && (cur_rd <= near_threshold_cm);

    assign rem_sh  = {rem_reg, acc_reg[SW-1]};
    assign rem_sub = rem_sh - {1'b0, cnt_reg};
    assign rem_ge  = (rem_sh >= {1'b0, cnt_reg});

    assign mask_wide = {{USD_MASK_W{1'b0}}, mask_reg};

    assign sts.sweep_end = step_last;
    assign sts.scan_last = (scan_reg == SEC_TOP);
    assign sts.div_last  = (dcnt_reg == DIV_LAST);
    assign sts.out_free  = !ovalid_reg || !out_stall;

    always_comb
    begin
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        sec_next   = sec_reg;
        up_next    = up_reg;
        step_next  = step_reg;
        done_next  = done_reg;
        scan_next  = scan_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        mask_next  = mask_reg;
        dcnt_next  = dcnt_reg;
        angle_full = ANGLE_STEP_DEG * (int'(sec_reg) + 1);

        if (cmd.upd)
        begin
            if (step_reg == '0)
            begin
                for (int k = 0; k < NUM_SECTORS; k++)
                begin
                    prev_next[k] = cur_reg[k];
                    cur_next[k]  = '0;
                end
            end
            cur_next[s_eff] = new_val;
            up_next   = dir_up;
            sec_next  = dir_up ? s_eff + 1'b1 : s_eff - 1'b1;
            step_next = step_last ? '0 : step_reg + 1'b1;
            done_next = step_last;
            scan_next = '0;
            acc_next  = '0;
            cnt_next  = '0;
            rem_next  = '0;
            mask_next = '0;
            dcnt_next = '0;
        end

        if (cmd.scan)
        begin
            // sector 0 is shifted in first and ends at the MSB
            mask_next = {mask_reg[NUM_SECTORS-2:0], near};
            if (near)
            begin
                acc_next = acc_reg + SW'(cur_rd);
                cnt_next = cnt_reg + 1'b1;
            end
            scan_next = scan_reg + 1'b1;
        end

        if (cmd.div)
        begin
            // restoring division: the sum shifts out, quotient bits shift in
            rem_next  = rem_ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
            acc_next  = {acc_reg[SW-2:0], rem_ge};
            dcnt_next = dcnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        angle_next  = angle_reg;
        odone_next  = odone_reg;
        omask_next  = omask_reg;
        omean_next  = omean_reg;
        if (cmd.out_load)
        begin
            ovalid_next = 1'b1;
            angle_next  = USD_ANGLE_W'(angle_full);
            odone_next  = done_reg;
            omask_next  = done_reg ? mask_wide[USD_MASK_W-1:0] : '0;
            omean_next  = (done_reg && (cnt_reg != '0)) ? acc_reg[USD_DIST_W-1:0] : '0;
        end
        else if (!out_stall)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_SECTORS; k++)
            begin
                cur_reg[k]  <= '0;
                prev_reg[k] <= '0;
            end
            sec_reg    <= SEC_RST;
            up_reg     <= 1'b1;
            step_reg   <= '0;
            done_reg   <= 1'b0;
            scan_reg   <= '0;
            cnt_reg    <= '0;
            dcnt_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            cur_reg    <= cur_next;
            prev_reg   <= prev_next;
            sec_reg    <= sec_next;
            up_reg     <= up_next;
            step_reg   <= step_next;
            done_reg   <= done_next;
            scan_reg   <= scan_next;
            cnt_reg    <= cnt_next;
            dcnt_reg   <= dcnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            echo_reg <= echo_duration_us;
        end
        if (cmd.mul)
        begin
            cm_reg <= prod[USD_RECIP_SHIFT +: USD_DIST_W];
        end
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        mask_reg  <= mask_next;
        angle_reg <= angle_next;
        odone_reg <= odone_next;
        omask_reg <= omask_next;
        omean_reg <= omean_next;
    end

    assign out_valid        = ovalid_reg;
    assign servo_angle      = angle_reg;
    assign sweep_done       = odone_reg;
    assign obstacle_mask    = omask_reg;
    assign mean_distance_cm = omean_reg;

endmodule

@@ sv/ultrasonic_sector_sweep_detector_top.sv @@
// ----------------------------------------------------------------------------
// ultrasonic_sector_sweep_detector_top
// Sector sweep obstacle detector fed with ultrasonic echo widths.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry one echo width word (microseconds)
// measured at the current servo sector. Output channel: out_valid / out_stall
// carry one result word per input word: the servo angle for the next
// measurement, and at the end of each sweep the sweep_done flag, the mask of
// sectors near in both sweeps and their mean distance.
// A word that does not end a sweep is converted, written to its sector and
// loaded into the output register (convert, sector update, output load),
// and the next word is taken only after that output load. A word that ends
// a sweep adds a scan of all NUM_SECTORS sectors and the serial mean
// divider, which forms 11+clog2(NUM_SECTORS) quotient bits, before its load.
// The near threshold is written over the APB port at byte address 0.
// Reset clears both sector stores, centers the servo index, starts a new
// sweep and sets the threshold to 30 cm. When the receiver stalls, the result
// holds in the output register while the next word is still accepted and
// processed; only its output load waits for the register to free.
// ----------------------------------------------------------------------------
module ultrasonic_sector_sweep_detector_top
    import usd_pkg::*;
#(
    parameter int NUM_SECTORS     = USD_NUM_SECTORS,
    parameter int STEPS_PER_SWEEP = USD_STEPS_PER_SWEEP,
    parameter int ANGLE_STEP_DEG  = USD_ANGLE_STEP_DEG
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [USD_ECHO_W-1:0]  echo_duration_us,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [USD_ANGLE_W-1:0] servo_angle,
    output logic                   sweep_done,
    output logic [USD_MASK_W-1:0]  obstacle_mask,
    output logic [USD_DIST_W-1:0]  mean_distance_cm,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [USD_ADDR_W-1:0]  paddr,
    input  logic [USD_DATA_W-1:0]  pwdata,
    output logic [USD_DATA_W-1:0]  prdata,
    output logic                   pready
);

    logic [USD_DIST_W-1:0] thresh_reg;
    logic [USD_DIST_W-1:0] thresh_next;
    logic                  thresh_sel;
    usd_cmd_t              cmd;
    usd_sts_t              sts;

    assign pready     = 1'b1;
    assign thresh_sel = (paddr[2] == USD_REG_THRESH);

    always_comb
    begin
        thresh_next = thresh_reg;
        if (psel && penable && pwrite && pready && thresh_sel)
        begin
            thresh_next = pwdata[USD_DIST_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= USD_THRESH_RST;
        end
        else
        begin
            thresh_reg <= thresh_next;
        end
    end

    assign prdata = thresh_sel ? USD_DATA_W'(thresh_reg) : '0;

    usd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    usd_dp
    #(
        .NUM_SECTORS     (NUM_SECTORS),
        .STEPS_PER_SWEEP (STEPS_PER_SWEEP),
        .ANGLE_STEP_DEG  (ANGLE_STEP_DEG)
    )
    u_dp
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .echo_duration_us  (echo_duration_us),
        .near_threshold_cm (thresh_reg),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .servo_angle       (servo_angle),
        .sweep_done        (sweep_done),
        .obstacle_mask     (obstacle_mask),
        .mean_distance_cm  (mean_distance_cm)
    );

endmodule
